/* hw/rtl/shabs_pkg.sv */
`timescale 1ns / 1ps

package shabs_pkg;

  // Item kinds on the request channel
  typedef enum logic {
    ACT_ABSORB = 1'b0,
    ACT_FINISH = 1'b1
  } action_e;

  // One queued request
  typedef struct packed {
    action_e    action;
    logic [7:0] data;
  } q_item_t;

  // Commands from the sequencer to the compression unit
  typedef struct packed {
    logic       load;   // shift one byte into the block window
    logic [7:0] data;
    logic       start;  // run 64 rounds over the window
    logic       init;   // return the chaining value to the initial hash
  } cmp_ctrl_t;

  typedef struct packed {
    logic busy;
  } cmp_stat_t;

  // Chaining value, word 0 first
  typedef logic [0:7][31:0] hash_t;

  localparam hash_t HASH_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [5:0]  LEN_POS    = 6'd56;
  localparam logic [5:0]  LAST_POS   = 6'd63;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* hw/rtl/shabs_in_if.sv */
`timescale 1ns / 1ps

interface shabs_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

/* hw/rtl/shabs_out_if.sv */
`timescale 1ns / 1ps

interface shabs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

/* hw/rtl/sha256_byte_stream_hasher_core.sv */
`timescale 1ns / 1ps
// SHA-256 over a byte stream.
// req_i carries one request per handshake: action 0 absorbs data_byte, action 1
// finishes the message. A finish pads the message, compresses, and returns the
// eight digest words on rsp_o, word_index 0 first, last_word set on the eighth.
// Absorb requests produce nothing on rsp_o.
// Requests land in a small queue (QUEUE_DEPTH entries), so up to QUEUE_DEPTH
// requests are taken while the sequencer works or a digest word waits on rsp_o.
// Bytes enter the block window one at a time; once a 64-byte block is full,
// the next byte is taken only after the compression is through: a start
// state, 64 rounds, the final add, and a wait state that sees the unit idle.
// A finish pads the message (into an extra block when the length does not
// fit) and runs one or two compressions; then the digest words leave one
// per cycle, while rsp_o is ready, through a registered output stage.
// If the receiver stalls rsp_o, the output word holds and the sequencer waits;
// the queue keeps taking requests until it is full.
// Reset loads the initial hash value and an empty message; no clearing pass is
// needed. Once the last digest word is loaded into the output stage, the block
// starts a new message on its own.
module sha256_byte_stream_hasher_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  shabs_in_if.sink    req_i,
  shabs_out_if.source rsp_o
);
  import shabs_pkg::*;

  logic      item_valid;
  logic      item_pop;
  q_item_t   item;
  cmp_ctrl_t cmp_ctrl;
  cmp_stat_t cmp_stat;
  hash_t     hash;

  shabs_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  shabs_compress u_compress (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cmp_ctrl),
    .stat_o (cmp_stat),
    .hash_o (hash)
  );

  shabs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .cmp_ctrl_o   (cmp_ctrl),
    .cmp_stat_i   (cmp_stat),
    .hash_i       (hash),
    .rsp_o        (rsp_o)
  );

endmodule

/* hw/rtl/shabs_front.sv */
`timescale 1ns / 1ps

module shabs_front #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  shabs_in_if.sink          req_i,
  output logic              item_valid_o,
  output shabs_pkg::q_item_t item_o,
  input  logic              item_pop_i
);
  import shabs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t          slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign req_i.ready  = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign push         = req_i.valid && req_i.ready;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = slot_q[rd_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the accepted request, tagged by kind
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= '{action: action_e'(req_i.action), data: req_i.data_byte};
    end
  end

endmodule

/* hw/rtl/shabs_compress.sv */
`timescale 1ns / 1ps

module shabs_compress (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  shabs_pkg::cmp_ctrl_t ctrl_i,
  output shabs_pkg::cmp_stat_t stat_o,
  output shabs_pkg::hash_t     hash_o
);
  import shabs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0]   state_q, state_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [511:0] win_q, win_d;   // block bytes, then the 16-word schedule window
  hash_t        work_q, work_d; // a..h
  hash_t        hash_q, hash_d;

  logic [31:0] wt, new_w, t1, t2, ch, maj;
  logic [31:0] a, b, c, d, e, f, g, h;

  assign {a, b, c, d, e, f, g, h} = work_q;

  // Schedule: window holds W[t..t+15], oldest word on top
  assign wt    = win_q[511:480];
  assign new_w = wt + ssig0(win_q[479:448]) + win_q[223:192] + ssig1(win_q[63:32]);

  // Round function
  assign ch  = (e & f) ^ (~e & g);
  assign maj = (a & b) ^ (a & c) ^ (b & c);
  assign t1  = h + bsig1(e) + ch + ROUND_K[rnd_q] + wt;
  assign t2  = bsig0(a) + maj;

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    win_d   = win_q;
    work_d  = work_q;
    hash_d  = hash_q;
    case (state_q)
      ST_IDLE: begin
        if (ctrl_i.load) begin
          win_d = {win_q[503:0], ctrl_i.data};
        end
        if (ctrl_i.init) begin
          hash_d = HASH_IV;
        end
        if (ctrl_i.start) begin
          work_d  = hash_q;
          rnd_d   = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        win_d  = {win_q[479:0], new_w};
        work_d = {t1 + t2, a, b, c, d + t1, e, f, g};
        rnd_d  = rnd_q + 1'b1;
        if (rnd_q == LAST_POS) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + work_q[i];
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      hash_q  <= HASH_IV;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      hash_q  <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    work_q <= work_d;
  end

  assign stat_o.busy = (state_q != ST_IDLE);
  assign hash_o      = hash_q;

endmodule

/* hw/rtl/shabs_back.sv */
`timescale 1ns / 1ps

module shabs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  shabs_pkg::q_item_t   item_i,
  output logic                 item_pop_o,
  output shabs_pkg::cmp_ctrl_t cmp_ctrl_o,
  input  shabs_pkg::cmp_stat_t cmp_stat_i,
  input  shabs_pkg::hash_t     hash_i,
  shabs_out_if.source          rsp_o
);
  import shabs_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_PAD   = 3'd1;
  localparam logic [2:0] B_START = 3'd2;
  localparam logic [2:0] B_WAIT  = 3'd3;
  localparam logic [2:0] B_EMIT  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;      // byte position in the current block
  logic [63:0] bits_q, bits_d;      // completed bits; message length once padding starts
  logic        pad_q, pad_d;        // padding in progress
  logic        last_blk_q, last_blk_d;
  logic [2:0]  emit_q, emit_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        out_last_q, out_last_d;

  logic        out_free;
  logic [7:0]  len_byte, pad_data;

  assign out_free = !out_valid_q || rsp_o.ready;

  // Length bytes go big-endian into positions 56..63 of the final block
  assign len_byte = bits_q[(6'd63 - {fill_q[2:0], 3'b000}) -: 8];
  assign pad_data = (last_blk_q && (fill_q >= LEN_POS)) ? len_byte : 8'h00;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    bits_d      = bits_q;
    pad_d       = pad_q;
    last_blk_d  = last_blk_q;
    emit_d      = emit_q;
    item_pop_o  = 1'b0;
    cmp_ctrl_o  = '0;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;

    case (state_q)
      // Take one request: absorb a byte, or start padding on finish
      B_IDLE: begin
        if (item_valid_i) begin
          item_pop_o      = 1'b1;
          cmp_ctrl_o.load = 1'b1;
          fill_d          = fill_q + 1'b1;
          if (item_i.action == ACT_FINISH) begin
            cmp_ctrl_o.data = PAD_BYTE;
            bits_d          = bits_q + {55'd0, fill_q, 3'b000};
            pad_d           = 1'b1;
            last_blk_d      = (fill_q < LEN_POS);
            state_d         = (fill_q == LAST_POS) ? B_START : B_PAD;
          end else begin
            cmp_ctrl_o.data = item_i.data;
            if (fill_q == LAST_POS) begin
              bits_d  = bits_q + BLOCK_BITS;
              state_d = B_START;
            end
          end
        end
      end
      // Fill the block with zeros and, in the last block, the length
      B_PAD: begin
        cmp_ctrl_o.load = 1'b1;
        cmp_ctrl_o.data = pad_data;
        fill_d          = fill_q + 1'b1;
        if (fill_q == LAST_POS) begin
          state_d = B_START;
        end
      end
      B_START: begin
        cmp_ctrl_o.start = 1'b1;
        state_d          = B_WAIT;
      end
      // Hold until the rounds are done, then pick the next step
      B_WAIT: begin
        if (!cmp_stat_i.busy) begin
          if (!pad_q) begin
            state_d = B_IDLE;
          end else if (last_blk_q) begin
            emit_d  = '0;
            state_d = B_EMIT;
          end else begin
            last_blk_d = 1'b1;
            state_d    = B_PAD;
          end
        end
      end
      // Emit the digest words, then restart for a new message
      B_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = hash_i[emit_q];
          out_idx_d   = emit_q;
          out_last_d  = (emit_q == 3'd7);
          emit_d      = emit_q + 1'b1;
          if (emit_q == 3'd7) begin
            cmp_ctrl_o.init = 1'b1;
            bits_d          = '0;
            fill_d          = '0;
            pad_d           = 1'b0;
            state_d         = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      fill_q      <= '0;
      bits_q      <= '0;
      pad_q       <= 1'b0;
      last_blk_q  <= 1'b0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bits_q      <= bits_d;
      pad_q       <= pad_d;
      last_blk_q  <= last_blk_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.digest_word = out_word_q;
  assign rsp_o.word_index  = out_idx_q;
  assign rsp_o.last_word   = out_last_q;

endmodule
